[rtl/core/clws_pkg.sv]
package clws_pkg;

  localparam int unsigned NumBits   = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(NumBits);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  localparam logic [BitCntW-1:0] LastBit   = BitCntW'(NumBits - 1);
  localparam logic [DigCntW-1:0] LastDigit = DigCntW'(NumDigits - 1);

  // request kinds
  localparam logic [2:0] MODE_CHAR   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_CURSOR = 3'd2;
  localparam logic [2:0] MODE_NUMBER = 3'd3;
  localparam logic [2:0] MODE_INIT   = 3'd4;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  localparam logic [7:0] ROW0_BASE   = 8'd128;
  localparam logic [7:0] ROW1_OFFSET = 8'd64;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  localparam logic [1:0] INIT_LAST = 2'd2;

  typedef enum logic [1:0] {
    SRC_DATA_BYTE,
    SRC_CURSOR,
    SRC_INIT,
    SRC_DIGIT
  } push_src_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      dig_shift;
    logic      push;
    push_src_e push_src;
    logic      push_rs;
    logic      push_last;
    logic [1:0] init_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] row;
    logic       out_free;
    logic       top_zero;
  } sts_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'b0011_1000;
      2'd1:    b = 8'b0000_1100;
      default: b = 8'b0000_0001;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/clws_dpath.sv]
module clws_dpath import clws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [79:0] in_data_i,
  input  logic [2:0]  in_mode_i,
  input  logic        m_axis_tready_i,
  output logic        m_axis_tvalid_o,
  output logic [7:0]  m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic [2:0]         mode_q;
  logic [7:0]         byte_q;
  logic [5:0]         col_q;
  logic [1:0]         row_q;
  logic [NumBits-1:0] bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d, bcd_adj;

  logic       out_valid_q;
  logic       out_rs_q, out_last_q;
  logic [7:0] out_byte_q;
  logic [7:0] push_byte;
  logic [3:0] top_digit;

  assign top_digit = bcd_q[BcdW-1 -: 4];

  // add-3 correction per digit, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= BCD_ADJ_MIN) ?
                          bcd_q[4*i +: 4] + BCD_ADJ : bcd_q[4*i +: 4];
    end
    bcd_d = bcd_q;
    bin_d = bin_q;
    if (cmd_i.load) begin
      bcd_d = '0;
      bin_d = in_data_i[79:16];
    end else if (cmd_i.conv_step) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[NumBits-1]};
      bin_d = {bin_q[NumBits-2:0], 1'b0};
    end else if (cmd_i.dig_shift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  always_comb begin
    case (cmd_i.push_src)
      SRC_DATA_BYTE: push_byte = byte_q;
      SRC_CURSOR:    push_byte = ROW0_BASE + (row_q[0] ? ROW1_OFFSET : 8'd0) + {2'b00, col_q};
      SRC_INIT:      push_byte = init_byte(cmd_i.init_idx);
      SRC_DIGIT:     push_byte = ASCII_ZERO + {4'd0, top_digit};
      default:       push_byte = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      byte_q <= in_data_i[7:0];
      col_q  <= in_data_i[13:8];
      row_q  <= in_data_i[15:14];
    end
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    if (cmd_i.push) begin
      out_rs_q   <= cmd_i.push_rs;
      out_last_q <= cmd_i.push_last;
      out_byte_q <= push_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.row      = row_q;
  assign sts_o.out_free = !out_valid_q || m_axis_tready_i;
  assign sts_o.top_zero = (top_digit == 4'd0);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_rs_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/core/clws_ctrl.sv]
module clws_ctrl import clws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SINGLE,
    ST_INIT,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         init_cnt_q, init_cnt_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               seen_q, seen_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.push_src = SRC_DATA_BYTE;
    cmd_o.init_idx = init_cnt_q;
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    bit_cnt_d  = bit_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    seen_d     = seen_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        init_cnt_d = 2'd0;
        bit_cnt_d  = '0;
        dig_cnt_d  = '0;
        seen_d     = 1'b0;
        case (sts_i.mode)
          MODE_CHAR, MODE_CMD: state_d = ST_SINGLE;
          MODE_CURSOR:         state_d = sts_i.row[1] ? ST_IDLE : ST_SINGLE;
          MODE_NUMBER:         state_d = ST_CONV;
          MODE_INIT:           state_d = ST_INIT;
          default:             state_d = ST_IDLE;
        endcase
      end
      ST_SINGLE: begin
        cmd_o.push_last = 1'b1;
        cmd_o.push_rs   = (sts_i.mode == MODE_CHAR) ? RS_DATA : RS_COMMAND;
        cmd_o.push_src  = (sts_i.mode == MODE_CURSOR) ? SRC_CURSOR : SRC_DATA_BYTE;
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd_o.push_rs   = RS_COMMAND;
        cmd_o.push_src  = SRC_INIT;
        cmd_o.push_last = (init_cnt_q == INIT_LAST);
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          init_cnt_d = init_cnt_q + 2'd1;
          if (init_cnt_q == INIT_LAST) state_d = ST_IDLE;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        bit_cnt_d       = bit_cnt_q + 1'b1;
        if (bit_cnt_q == LastBit) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.push_rs   = RS_DATA;
        cmd_o.push_src  = SRC_DIGIT;
        cmd_o.push_last = (dig_cnt_q == LastDigit);
        // drop leading zeros, but always print the units digit
        if (sts_i.top_zero && !seen_q && dig_cnt_q != LastDigit) begin
          cmd_o.dig_shift = 1'b1;
          dig_cnt_d       = dig_cnt_q + 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.dig_shift = 1'b1;
          seen_d          = 1'b1;
          dig_cnt_d       = dig_cnt_q + 1'b1;
          if (dig_cnt_q == LastDigit) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      init_cnt_q <= 2'd0;
      bit_cnt_q  <= '0;
      dig_cnt_q  <= '0;
      seen_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      dig_cnt_q  <= dig_cnt_d;
      seen_q     <= seen_d;
    end
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free)
    else $error("write pushed into a busy output register");

  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DECODE)
    else $error("accepted request not decoded");

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && bit_cnt_q == LastBit) |=> state_q == ST_EMIT)
    else $error("conversion did not hand over to digit output");

  a_digit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !sts_i.top_zero && cmd_o.dig_shift) |-> cmd_o.push)
    else $error("nonzero digit dropped");

endmodule

[rtl/core/char_lcd_write_sequencer_unit.sv]
// Character LCD write sequencer.
// Input stream (s_axis): one request per item. tuser carries the request kind
// (character, command, set cursor, print number, initialise); tdata carries
// the byte, cursor column and row, and the 64-bit number to print.
// Output stream (m_axis): one LCD register write per item. tuser is the
// register select (0 command, 1 data), tdata the bus byte, tlast marks the
// final write of a request. Cursor requests on rows two and three and unused
// kinds produce no write at all.
// A character, command or cursor request gives one write; initialise gives
// three command writes. Print number runs a 64-step shift-and-add-3
// binary-to-BCD loop, one bit per cycle, then walks the 20 BCD digits one per
// cycle while the receiver takes writes, skipping leading zeros without output.
// One request is in work at a time; tready is high while the sequencer is
// idle, also while the final write of the previous request waits in the output
// register. When the receiver stalls, the output register holds its write and
// the sequencer waits. Reset clears the controller and the output valid.
module char_lcd_write_sequencer_unit import clws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // data_byte[7:0], column[13:8], row[15:14],
                                       // number_value[79:16]
  input  logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // bus_byte[7:0]
  output logic [0:0]  m_axis_tuser_o,  // reg_select[0]
  output logic        m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  // sequence the request
  clws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold request fields, convert the number, drive the output register
  clws_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_data_i       (s_axis_tdata_i),
    .in_mode_i       (s_axis_tuser_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import clws_pkg::*;

  // Kinds outside the defined set; the sequencer must drop them silently.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  // Power-up sequence bytes: function set, display on, clear.
  localparam logic [7:0] INIT_FUNC_SET   = 8'h38;
  localparam logic [7:0] INIT_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] INIT_CLEAR      = 8'h01;

  localparam logic [63:0] DEC_BASE = 64'd10;

  localparam int unsigned SETTLE_CYCLES = 100;     // longer than one print
  localparam int unsigned LONG_HOLD     = 400;     // receiver back-pressure run
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [63:0] number_value;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  lcd_req_t   pending_reqs[$];
  lcd_write_t expected_writes[$];
  lcd_req_t   offered_req = '0;
  logic       req_taken   = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_req_count = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  int err_count    = 0;
  int req_count    = 0;
  int write_count  = 0;
  int number_count = 0;
  int unsigned cycle_count = 0;

  char_lcd_write_sequencer_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one LCD register write to the expected stream.
  function automatic void push_write(input logic rs, input logic [7:0] b);
    lcd_write_t w;
    w.rs       = rs;
    w.bus_byte = b;
    w.last     = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // Expand one request into the LCD writes it should produce, in order.
  function automatic void predict_writes(input lcd_req_t r);
    logic [3:0]  digits [NumDigits];
    logic [63:0] v;
    int          n;
    int          start_size;
    lcd_write_t  w;
    start_size = expected_writes.size();
    n = 0;
    case (r.mode)
      MODE_CHAR: push_write(RS_DATA, r.data_byte);
      MODE_CMD:  push_write(RS_COMMAND, r.data_byte);
      MODE_CURSOR: begin
        // rows two and three give no write
        if (r.row == 2'd0) begin
          push_write(RS_COMMAND, ROW0_BASE + {2'b00, r.column});
        end else if (r.row == 2'd1) begin
          push_write(RS_COMMAND, ROW0_BASE + ROW1_OFFSET + {2'b00, r.column});
        end
      end
      MODE_NUMBER: begin
        // collect digits least significant first; zero still yields one '0'
        v = r.number_value;
        do begin
          digits[n] = 4'(v % DEC_BASE);
          v = v / DEC_BASE;
          n++;
        end while (v != 64'd0);
        while (n > 0) begin
          n--;
          push_write(RS_DATA, ASCII_ZERO + {4'd0, digits[n]});
        end
      end
      MODE_INIT: begin
        push_write(RS_COMMAND, INIT_FUNC_SET);
        push_write(RS_COMMAND, INIT_DISPLAY_ON);
        push_write(RS_COMMAND, INIT_CLEAR);
      end
      default: ;
    endcase
    // flag the final write of this request
    if (expected_writes.size() > start_size) begin
      w = expected_writes.pop_back();
      w.last = 1'b1;
      expected_writes.push_back(w);
    end
  endfunction

  function automatic lcd_req_t make_req(input logic [2:0] mode, input logic [7:0] b,
                                        input logic [5:0] col, input logic [1:0] row,
                                        input logic [63:0] num);
    lcd_req_t r;
    r.mode         = mode;
    r.data_byte    = b;
    r.column       = col;
    r.row          = row;
    r.number_value = num;
    return r;
  endfunction

  // Mix of zero, small values, full-width values, decade edges and near-max.
  function automatic logic [63:0] random_number();
    logic [63:0] v;
    logic [63:0] p;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'd0;
      1: v = 64'($urandom_range(999));
      2: ;
      3: v = v >> $urandom_range(63);
      4: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * DEC_BASE;
        v = p - 64'($urandom_range(1));
      end
      default: v = ~64'($urandom_range(15));
    endcase
    return v;
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       pick;
    r.data_byte    = 8'($urandom);
    r.column       = 6'($urandom);
    r.row          = 2'($urandom);
    r.number_value = random_number();
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.mode = MODE_CHAR;
    end else if (pick < 24) begin
      r.mode = MODE_CMD;
    end else if (pick < 44) begin
      r.mode = MODE_CURSOR;
      // favor the two real rows
      if ($urandom_range(9) < 8) r.row = {1'b0, r.row[0]};
    end else if (pick < 84) begin
      r.mode = MODE_NUMBER;
    end else if (pick < 94) begin
      r.mode = MODE_INIT;
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    end
    return r;
  endfunction

  // Request driver: advance on acceptance, otherwise hold the offered request.
  always @(negedge clk) begin
    if (rst_n && (!s_valid || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        offered_req <= pending_reqs[0];
        s_tdata     <= {pending_reqs[0].number_value, pending_reqs[0].row,
                        pending_reqs[0].column, pending_reqs[0].data_byte};
        s_tuser     <= pending_reqs[0].mode;
        s_valid     <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Write receiver: random stalls, plus a long counted hold when asked.
  always @(negedge clk) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (hold_req_count != hold_seen) begin
      hold_seen <= hold_req_count;
      hold_left <= LONG_HOLD;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: check each accepted write against the oldest expectation, then
  // expand any request accepted at this same edge.
  always @(posedge clk) begin : monitor
    lcd_write_t got;
    lcd_write_t want;
    req_taken <= s_valid && s_ready;
    if (rst_n && m_valid && m_ready) begin
      got.rs       = m_tuser[0];
      got.bus_byte = m_tdata;
      got.last     = m_tlast;
      write_count++;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write rs=%0d byte=%02h last=%0d",
                 $time, got.rs, got.bus_byte, got.last);
        err_count++;
      end else begin
        want = expected_writes.pop_front();
        if (got.rs != want.rs || got.bus_byte != want.bus_byte || got.last != want.last) begin
          $display("%0t: mismatch expected rs=%0d byte=%02h last=%0d, got rs=%0d byte=%02h last=%0d",
                   $time, want.rs, want.bus_byte, want.last,
                   got.rs, got.bus_byte, got.last);
          err_count++;
        end
      end
    end
    if (rst_n && s_valid && s_ready) begin
      predict_writes(offered_req);
      req_count++;
      if (offered_req.mode == MODE_NUMBER) number_count++;
    end
  end

  // Watchdog: fail the run once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Wait for every queued request to go out and every write to come back,
  // then let the sequencer settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || s_valid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int n_items,
                           input bit long_hold);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (long_hold) hold_req_count++;
    repeat (n_items) pending_reqs.push_back(random_request());
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed: field extremes, each kind, dropped rows and kinds, digit edges.
    pending_reqs.push_back(make_req(MODE_CHAR, 8'h00, 6'd0, 2'd0, random_number()));
    pending_reqs.push_back(make_req(MODE_CHAR, 8'hFF, 6'd63, 2'd3, '1));
    pending_reqs.push_back(make_req(MODE_CMD, 8'h00, 6'd63, 2'd1, '0));
    pending_reqs.push_back(make_req(MODE_CMD, 8'hFF, 6'd0, 2'd2, '1));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'hFF, 6'd0, 2'd0, '1));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'h00, 6'd63, 2'd0, '0));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'hA5, 6'd0, 2'd1, '1));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'h5A, 6'd63, 2'd1, '0));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'h11, 6'd5, 2'd2, '1));
    pending_reqs.push_back(make_req(MODE_CURSOR, 8'h22, 6'd63, 2'd3, '0));
    pending_reqs.push_back(make_req(MODE_INIT, 8'hFF, 6'd63, 2'd3, '1));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'hFF, 6'd63, 2'd3, 64'd0));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0, 64'd1));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0, 64'd9));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0, 64'd10));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h3C, 6'd17, 2'd1, 64'd12345));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0,
                                    64'd9999999999999999999));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0,
                                    64'd10000000000000000000));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(make_req(MODE_NUMBER, 8'h00, 6'd0, 2'd0, '1));
    pending_reqs.push_back(make_req(MODE_SPARE_FIRST, 8'hFF, 6'd63, 2'd0, '1));
    pending_reqs.push_back(make_req(MODE_INIT + 3'd2, 8'h00, 6'd0, 2'd1, '0));
    pending_reqs.push_back(make_req(MODE_SPARE_LAST, 8'h81, 6'd1, 2'd0, 64'd7));
    pending_reqs.push_back(make_req(MODE_CHAR, 8'h41, 6'd0, 2'd0, '0));
    drain();

    // Random phases: free flow, sparse sender, stalling receiver, both.
    run_phase(0, 0, 90, 1'b0);
    run_phase(82, 0, 90, 1'b0);
    run_phase(0, 82, 90, 1'b0);
    run_phase(16, 16, 100, 1'b0);
    // Long receiver hold while the sender keeps offering requests.
    run_phase(0, 0, 30, 1'b1);

    $display("Ran %0d requests (%0d number prints) over five flow-control phases;",
             req_count, number_count);
    $display("checked %0d LCD writes against the predicted sequence.", write_count);
    if (err_count == 0 && expected_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/clws_pkg.sv
rtl/core/clws_dpath.sv
rtl/core/clws_ctrl.sv
rtl/core/char_lcd_write_sequencer_unit.sv
tb/tb.sv
